@@ hw/rtl/tracker_row_sequencer_unit_macros.svh @@
// Assertion macros for the tracker row sequencer.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef TRACKER_ROW_SEQUENCER_UNIT_MACROS_SVH
`define TRACKER_ROW_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication under reset.
`define TRS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trs: same-cycle check failed");

// Next-cycle implication under reset.
`define TRS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trs: next-cycle check failed");

`endif

@@ hw/rtl/trs_pkg.sv @@
// Package for the tracker row sequencer: item types, codes and constants.
// No dependencies; used by tracker_row_sequencer_unit.
`default_nettype none

package trs_pkg;

    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_ADVANCE = 3'd1;
    localparam logic [2:0] REQ_KILL    = 3'd2;
    localparam logic [2:0] REQ_WIND    = 3'd3;
    localparam logic [2:0] REQ_RESET   = 3'd4;

    localparam logic [1:0] ROW_EMPTY    = 2'd0;
    localparam logic [1:0] ROW_NOTE_ON  = 2'd1;
    localparam logic [1:0] ROW_NOTE_OFF = 2'd2;
    localparam logic [1:0] ROW_BAD      = 2'd3;

    localparam logic [2:0] CFG_ROW_COUNT      = 3'd0;
    localparam logic [2:0] CFG_SONG_ROWS      = 3'd1;
    localparam logic [2:0] CFG_LOOP_ENABLE    = 3'd2;
    localparam logic [2:0] CFG_MIDI_CHANNEL   = 3'd3;
    localparam logic [2:0] CFG_PLAY_ENABLE    = 3'd4;
    localparam logic [2:0] CFG_ACTIVE_COLUMNS = 3'd5;
    localparam logic [2:0] CFG_BUFFER_FRAMES  = 3'd6;

    localparam logic [9:0]  DELAY_MAX  = 10'd999;
    localparam logic [12:0] FRAME_MAX  = 13'd8191;
    localparam int          EVT_W      = 6;
    localparam logic [5:0]  MAX_EVENTS = 6'd40;
    localparam int          N_W        = 17;
    localparam int          FRAME_BITS = 14;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WDIV,
        S_PREP,
        S_FDIV,
        S_COL,
        S_RD,
        S_CHK,
        S_MUL,
        S_FLD,
        S_FRDIV,
        S_OFF,
        S_ON,
        S_NEXT,
        S_KILL,
        S_POS,
        S_PDIV,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  column;
        logic [7:0]  row_index;
        logic [1:0]  row_type;
        logic [6:0]  note_value;
        logic [6:0]  velocity_value;
        logic [9:0]  row_delay;
        logic [23:0] period;
    } request_t;

    typedef struct packed {
        logic [12:0] frame_offset;
        logic [3:0]  channel;
        logic        event_kind;
        logic [6:0]  note_out;
        logic [6:0]  velocity_out;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic [9:0] delay;
    } row_t;

endpackage

`default_nettype wire

@@ hw/rtl/tracker_row_sequencer_unit.sv @@
// Tracker row sequencer: row store, play position and MIDI event generation.
// Depends on trs_pkg and tracker_row_sequencer_unit_macros.svh.
// A row write or a position reset is done in the idle state; busy stays low.
// Advance divides for the window, reads and checks each scanned row, and divides
// again per triggered row; one shared restoring divider (QW = max(RC_W+24, 33)).
// Kill visits each active column in turn, then flushes. Events leave one per strobe.
// After reset the row store is cleared, one entry a cycle, all COLUMNS*ROWS entries.
// Results cannot be stalled; reset clears position and notes, sets config defaults.
`default_nettype none
`include "tracker_row_sequencer_unit_macros.svh"

module tracker_row_sequencer_unit #(
    parameter int COLUMNS         = 4,
    parameter int ROWS            = 256,
    parameter int MAX_WINDOW_ROWS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire trs_pkg::request_t request,
    output logic                   result_valid,
    output trs_pkg::result_t       result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_addr,
    input  wire logic [15:0]       cfg_wdata
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(ROWS);
    localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int NC_W   = $clog2(COLUMNS + 1);
    localparam int RC_W   = $clog2(ROWS + 1);
    localparam int CAP    = MAX_WINDOW_ROWS * 65536;
    localparam int TW     = $clog2(CAP + 1);
    localparam int SPAN_W = $clog2(CAP * 1000 + 1);
    localparam int PROD_W = RC_W + 24;
    localparam int QW     = (PROD_W > 33) ? PROD_W : 33;
    localparam int LIM_W  = RC_W + 16;
    localparam int DV_W   = (SPAN_W > LIM_W) ? SPAN_W : LIM_W;
    localparam int REM_W  = DV_W + 1;
    localparam int CNT_W  = $clog2(QW + 1);
    localparam int FP_W   = SPAN_W + trs_pkg::FRAME_BITS;
    localparam int NK_W   = trs_pkg::N_W + 10;

    trs_pkg::state_t state_reg, state_next;

    logic [8:0]  row_count_reg;
    logic [15:0] song_rows_reg;
    logic        loop_reg;
    logic [3:0]  chan_reg;
    logic        play_reg;
    logic [2:0]  act_cols_reg;
    logic [13:0] frames_reg;

    logic [31:0] pos_reg;
    logic [COLUMNS-1:0] snd_valid_reg;
    logic [6:0]  snd_note_reg [COLUMNS];

    trs_pkg::row_t mem [DEPTH];
    trs_pkg::row_t mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    trs_pkg::row_t mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] clr_addr_reg;

    logic [QW-1:0]    div_q_reg;
    logic [REM_W-1:0] div_r_reg;
    logic [DV_W-1:0]  div_d_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic             div_load;
    logic [QW-1:0]    div_q_load;
    logic [REM_W-1:0] div_r_load;
    logic [DV_W-1:0]  div_d_load;
    logic [CNT_W-1:0] div_cnt_load;
    logic [REM_W-1:0] div_shift;
    logic             div_ge;
    logic [REM_W-1:0] div_r_step;

    logic [2:0]        req_reg;
    logic [TW-1:0]     t_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [41:0]       base_reg;
    logic [15:0]       first_reg;
    logic [trs_pkg::N_W-1:0] lastn_reg;
    logic [trs_pkg::N_W-1:0] n_reg;
    logic [NK_W-1:0]   n1000_reg;
    logic [IDX_W-1:0]  fmod_reg;
    logic [IDX_W-1:0]  lidx_reg;
    logic [CW-1:0]     col_reg;
    trs_pkg::row_t     row_reg;
    logic [SPAN_W-1:0] diff_reg;
    logic [FP_W-1:0]   fprod_reg;
    logic [12:0]       frame_reg;

    logic [trs_pkg::EVT_W-1:0] evt_cnt_reg;
    logic             pend_valid_reg;
    trs_pkg::result_t pend_evt_reg;
    logic             out_valid_reg;
    trs_pkg::result_t result_reg;
    logic             emit_req;
    trs_pkg::result_t emit_evt;
    logic             emit_ok;

    logic             accept;
    logic [RC_W-1:0]  rc_eff;
    logic [15:0]      sr_eff;
    logic [NC_W-1:0]  nc_eff;
    logic [LIM_W-1:0] lim;
    logic [32:0]      pos_plus_t;
    logic             col_last;
    logic             scan_go;
    logic             pos_wrap;
    logic [IDX_W-1:0] scan_idx;
    logic [NK_W-1:0]  tn;
    logic [42:0]      trig;
    logic [42:0]      trig_d;
    logic             row_hit;
    logic             wr_ok;
    logic [1:0]       wr_kind;
    logic [9:0]       wr_delay;
    logic [13:0]      frame_q;

    assign accept     = start && (state_reg == trs_pkg::S_IDLE);
    assign sr_eff     = (song_rows_reg == 16'd0) ? 16'd1 : song_rows_reg;
    assign lim        = {rc_eff, 16'b0};
    assign pos_plus_t = {1'b0, pos_reg} + 33'(t_reg);
    assign col_last   = (32'(col_reg) + 32'd1) == 32'(nc_eff);
    assign scan_go    = play_reg && (nc_eff != '0);
    assign pos_wrap   = loop_reg && (pos_plus_t > 33'(lim));
    assign scan_idx   = loop_reg ? lidx_reg : n_reg[IDX_W-1:0];
    assign rd_addr    = AW'(32'(col_reg) * ROWS + 32'(scan_idx));
    assign emit_ok    = emit_req && (evt_cnt_reg < trs_pkg::MAX_EVENTS);
    assign frame_q    = div_q_reg[trs_pkg::FRAME_BITS-1:0];

    always_comb
    begin
        if (row_count_reg == 9'd0)
        begin
            rc_eff = RC_W'(1);
        end
        else if (32'(row_count_reg) > ROWS)
        begin
            rc_eff = RC_W'(ROWS);
        end
        else
        begin
            rc_eff = RC_W'(row_count_reg);
        end
        if (32'(act_cols_reg) > COLUMNS)
        begin
            nc_eff = NC_W'(COLUMNS);
        end
        else
        begin
            nc_eff = NC_W'(act_cols_reg);
        end
    end

    always_comb
    begin
        tn      = n1000_reg + NK_W'(mem_rdata_reg.delay);
        trig    = {tn, 16'b0};
        trig_d  = trig - {1'b0, base_reg};
        row_hit = (loop_reg || (32'(n_reg) < 32'(rc_eff)))
               && (trig >= {1'b0, base_reg})
               && (trig_d < 43'(span_reg))
               && ((mem_rdata_reg.kind == trs_pkg::ROW_NOTE_ON)
                || (mem_rdata_reg.kind == trs_pkg::ROW_NOTE_OFF));
    end

    always_comb
    begin
        div_shift  = {div_r_reg[REM_W-2:0], div_q_reg[QW-1]};
        div_ge     = div_shift >= {1'b0, div_d_reg};
        div_r_step = div_ge ? (div_shift - {1'b0, div_d_reg}) : div_shift;
    end

    always_comb
    begin
        div_load     = 1'b0;
        div_q_load   = QW'(PROD_W'(rc_eff) * PROD_W'(request.period));
        div_r_load   = '0;
        div_d_load   = DV_W'(sr_eff);
        div_cnt_load = CNT_W'(QW);
        case (state_reg)
            trs_pkg::S_IDLE:
            begin
                div_load = accept && ((request.req_type == trs_pkg::REQ_ADVANCE)
                                   || (request.req_type == trs_pkg::REQ_WIND));
            end
            trs_pkg::S_PREP:
            begin
                div_load   = (req_reg == trs_pkg::REQ_ADVANCE) && scan_go && loop_reg;
                div_q_load = QW'(pos_reg[31:16]);
                div_d_load = DV_W'(rc_eff);
            end
            trs_pkg::S_FLD:
            begin
                div_load     = 1'b1;
                div_q_load   = {fprod_reg[trs_pkg::FRAME_BITS-1:0],
                                {(QW - trs_pkg::FRAME_BITS){1'b0}}};
                div_r_load   = REM_W'(fprod_reg[FP_W-1:trs_pkg::FRAME_BITS]);
                div_d_load   = DV_W'(span_reg);
                div_cnt_load = CNT_W'(trs_pkg::FRAME_BITS);
            end
            trs_pkg::S_POS:
            begin
                div_load   = pos_wrap;
                div_q_load = QW'(pos_plus_t - 33'd1);
                div_d_load = DV_W'(lim);
            end
            default:
            begin
                div_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trs_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = trs_pkg::S_IDLE;
                end
            end
            trs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (request.req_type)
                        trs_pkg::REQ_ADVANCE, trs_pkg::REQ_WIND:
                        begin
                            state_next = trs_pkg::S_WDIV;
                        end
                        trs_pkg::REQ_KILL:
                        begin
                            state_next = (nc_eff == '0) ? trs_pkg::S_FLUSH : trs_pkg::S_KILL;
                        end
                        default:
                        begin
                            state_next = trs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            trs_pkg::S_WDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = trs_pkg::S_PREP;
                end
            end
            trs_pkg::S_PREP:
            begin
                if (req_reg == trs_pkg::REQ_WIND)
                begin
                    state_next = trs_pkg::S_FLUSH;
                end
                else if (scan_go)
                begin
                    state_next = loop_reg ? trs_pkg::S_FDIV : trs_pkg::S_COL;
                end
                else
                begin
                    state_next = trs_pkg::S_POS;
                end
            end
            trs_pkg::S_FDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = trs_pkg::S_COL;
                end
            end
            trs_pkg::S_COL:   state_next = trs_pkg::S_RD;
            trs_pkg::S_RD:    state_next = trs_pkg::S_CHK;
            trs_pkg::S_CHK:   state_next = row_hit ? trs_pkg::S_MUL : trs_pkg::S_NEXT;
            trs_pkg::S_MUL:   state_next = trs_pkg::S_FLD;
            trs_pkg::S_FLD:   state_next = trs_pkg::S_FRDIV;
            trs_pkg::S_FRDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = trs_pkg::S_OFF;
                end
            end
            trs_pkg::S_OFF:   state_next = trs_pkg::S_ON;
            trs_pkg::S_ON:    state_next = trs_pkg::S_NEXT;
            trs_pkg::S_NEXT:
            begin
                if (n_reg != lastn_reg)
                begin
                    state_next = trs_pkg::S_RD;
                end
                else
                begin
                    state_next = col_last ? trs_pkg::S_POS : trs_pkg::S_COL;
                end
            end
            trs_pkg::S_KILL:
            begin
                if (col_last)
                begin
                    state_next = trs_pkg::S_FLUSH;
                end
            end
            trs_pkg::S_POS:
            begin
                state_next = pos_wrap ? trs_pkg::S_PDIV : trs_pkg::S_FLUSH;
            end
            trs_pkg::S_PDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = trs_pkg::S_FLUSH;
                end
            end
            trs_pkg::S_FLUSH: state_next = trs_pkg::S_IDLE;
            default:          state_next = trs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy                  = (state_reg != trs_pkg::S_IDLE);
        emit_req              = 1'b0;
        emit_evt.frame_offset = frame_reg;
        emit_evt.channel      = chan_reg;
        emit_evt.event_kind   = 1'b0;
        emit_evt.note_out     = snd_note_reg[col_reg];
        emit_evt.velocity_out = 7'd0;
        emit_evt.last         = 1'b0;
        case (state_reg)
            trs_pkg::S_OFF:
            begin
                emit_req = snd_valid_reg[col_reg];
            end
            trs_pkg::S_ON:
            begin
                emit_req              = 1'b1;
                emit_evt.event_kind   = (row_reg.kind == trs_pkg::ROW_NOTE_ON);
                emit_evt.note_out     = row_reg.note;
                emit_evt.velocity_out = row_reg.vel;
            end
            trs_pkg::S_KILL:
            begin
                emit_req              = snd_valid_reg[col_reg];
                emit_evt.frame_offset = 13'd0;
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ok    = (32'(request.column) < COLUMNS) && (32'(request.row_index) < ROWS);
        wr_kind  = (request.row_type == trs_pkg::ROW_BAD) ? trs_pkg::ROW_EMPTY
                                                          : request.row_type;
        wr_delay = (request.row_delay > trs_pkg::DELAY_MAX) ? trs_pkg::DELAY_MAX
                                                            : request.row_delay;
        if (state_reg == trs_pkg::S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = accept && (request.req_type == trs_pkg::REQ_WRITE) && wr_ok;
            mem_waddr = AW'(32'(request.column) * ROWS + 32'(request.row_index));
            mem_wdata = {wr_kind, request.note_value, request.velocity_value, wr_delay};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= trs_pkg::S_CLEAR;
            row_count_reg  <= 9'd64;
            song_rows_reg  <= 16'd64;
            loop_reg       <= 1'b0;
            chan_reg       <= 4'd0;
            play_reg       <= 1'b1;
            act_cols_reg   <= 3'd1;
            frames_reg     <= 14'd256;
            pos_reg        <= '0;
            snd_valid_reg  <= '0;
            clr_addr_reg   <= '0;
            div_cnt_reg    <= '0;
            evt_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    trs_pkg::CFG_ROW_COUNT:      row_count_reg <= cfg_wdata[8:0];
                    trs_pkg::CFG_SONG_ROWS:      song_rows_reg <= cfg_wdata;
                    trs_pkg::CFG_LOOP_ENABLE:    loop_reg      <= cfg_wdata[0];
                    trs_pkg::CFG_MIDI_CHANNEL:   chan_reg      <= cfg_wdata[3:0];
                    trs_pkg::CFG_PLAY_ENABLE:    play_reg      <= cfg_wdata[0];
                    trs_pkg::CFG_ACTIVE_COLUMNS: act_cols_reg  <= cfg_wdata[2:0];
                    trs_pkg::CFG_BUFFER_FRAMES:  frames_reg    <= cfg_wdata[13:0];
                    default:                     ;
                endcase
            end
            if (state_reg == trs_pkg::S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (div_load)
            begin
                div_cnt_reg <= div_cnt_load;
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - CNT_W'(1);
            end
            case (state_reg)
                trs_pkg::S_IDLE:
                begin
                    if (accept && (request.req_type == trs_pkg::REQ_RESET))
                    begin
                        pos_reg       <= '0;
                        snd_valid_reg <= '0;
                    end
                end
                trs_pkg::S_PREP:
                begin
                    if (req_reg == trs_pkg::REQ_WIND)
                    begin
                        pos_reg <= pos_plus_t[32] ? '1 : pos_plus_t[31:0];
                    end
                end
                trs_pkg::S_POS:
                begin
                    if (!pos_wrap)
                    begin
                        pos_reg <= pos_plus_t[32] ? '1 : pos_plus_t[31:0];
                    end
                end
                trs_pkg::S_PDIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        pos_reg <= 32'(div_r_reg) + 32'd1;
                    end
                end
                trs_pkg::S_OFF, trs_pkg::S_KILL:
                begin
                    snd_valid_reg[col_reg] <= 1'b0;
                end
                trs_pkg::S_ON:
                begin
                    if (row_reg.kind == trs_pkg::ROW_NOTE_ON)
                    begin
                        snd_valid_reg[col_reg] <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (accept)
            begin
                evt_cnt_reg <= '0;
            end
            if (emit_ok)
            begin
                evt_cnt_reg    <= evt_cnt_reg + trs_pkg::EVT_W'(1);
                pend_valid_reg <= 1'b1;
                out_valid_reg  <= pend_valid_reg;
            end
            else if (state_reg == trs_pkg::S_FLUSH)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= pend_valid_reg;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_q_reg <= div_q_load;
            div_r_reg <= div_r_load;
            div_d_reg <= div_d_load;
        end
        else if (div_cnt_reg != '0)
        begin
            div_q_reg <= {div_q_reg[QW-2:0], div_ge};
            div_r_reg <= div_r_step;
        end
        if (emit_ok)
        begin
            result_reg   <= pend_evt_reg;
            pend_evt_reg <= emit_evt;
        end
        else if (state_reg == trs_pkg::S_FLUSH)
        begin
            result_reg      <= pend_evt_reg;
            result_reg.last <= 1'b1;
        end
        case (state_reg)
            trs_pkg::S_IDLE:
            begin
                req_reg <= request.req_type;
                col_reg <= '0;
            end
            trs_pkg::S_WDIV:
            begin
                t_reg <= (div_q_reg > QW'(CAP)) ? TW'(CAP) : div_q_reg[TW-1:0];
            end
            trs_pkg::S_PREP:
            begin
                span_reg  <= SPAN_W'(t_reg) * SPAN_W'(1000);
                base_reg  <= 42'(pos_reg) * 42'd1000;
                first_reg <= pos_reg[31:16];
                lastn_reg <= pos_plus_t[32:16];
                col_reg   <= '0;
            end
            trs_pkg::S_FDIV:
            begin
                fmod_reg <= div_r_reg[IDX_W-1:0];
            end
            trs_pkg::S_COL:
            begin
                n_reg     <= trs_pkg::N_W'(first_reg);
                n1000_reg <= NK_W'(first_reg) * NK_W'(1000);
                lidx_reg  <= fmod_reg;
            end
            trs_pkg::S_CHK:
            begin
                row_reg  <= mem_rdata_reg;
                diff_reg <= trig_d[SPAN_W-1:0];
            end
            trs_pkg::S_MUL:
            begin
                fprod_reg <= FP_W'(diff_reg) * FP_W'(frames_reg);
            end
            trs_pkg::S_FRDIV:
            begin
                frame_reg <= (frame_q > 14'(trs_pkg::FRAME_MAX)) ? trs_pkg::FRAME_MAX
                                                                 : frame_q[12:0];
            end
            trs_pkg::S_ON:
            begin
                if (row_reg.kind == trs_pkg::ROW_NOTE_ON)
                begin
                    snd_note_reg[col_reg] <= row_reg.note;
                end
            end
            trs_pkg::S_NEXT:
            begin
                if (n_reg != lastn_reg)
                begin
                    n_reg     <= n_reg + trs_pkg::N_W'(1);
                    n1000_reg <= n1000_reg + NK_W'(1000);
                    lidx_reg  <= ((32'(lidx_reg) + 32'd1) == 32'(rc_eff)) ? '0
                                 : lidx_reg + IDX_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            trs_pkg::S_KILL:
            begin
                col_reg <= col_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    `TRS_ASSERT_NEXT(a_last_ends_burst, result_valid && result.last, !result_valid)
    `TRS_ASSERT_NEXT(a_advance_busy, accept && (request.req_type == trs_pkg::REQ_ADVANCE), busy)
    `TRS_ASSERT_IMPL(a_event_cap, 1'b1, evt_cnt_reg <= trs_pkg::MAX_EVENTS)
    `TRS_ASSERT_IMPL(a_div_rem, div_cnt_reg != '0, div_r_reg < {1'b0, div_d_reg})

endmodule

`default_nettype wire
